>>> rtl/core/flal_pkg.sv
// shared types, constants and register codes of the attempt lockout limiter
package flal_pkg;

    localparam int TIME_BITS_DEF    = 48;
    localparam int USER_ID_BITS_DEF = 8;

    localparam int MS_W       = 32;
    localparam int US_PER_MS  = 1000;
    // ms * 1000 fits in 32 + 10 bits
    localparam int PROD_W     = MS_W + 10;
    localparam int COUNT_W    = 8;
    localparam int THRESH_W   = 8;
    localparam int OUTCOME_W  = 4;
    localparam int PERM_W     = 8;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [MS_W-1:0]     COOLDOWN_MS_RST = MS_W'(2000);
    localparam logic [THRESH_W-1:0] THRESHOLD_RST   = THRESH_W'(5);
    localparam logic [MS_W-1:0]     WINDOW_MS_RST   = MS_W'(60000);
    localparam logic [MS_W-1:0]     LOCKOUT_MS_RST  = MS_W'(300000);

    // sensor outcome codes
    localparam logic [OUTCOME_W-1:0] OUTCOME_OK          = OUTCOME_W'(0);
    localparam logic [OUTCOME_W-1:0] OUTCOME_NO_MATCH    = OUTCOME_W'(1);
    localparam logic [OUTCOME_W-1:0] OUTCOME_LAST_READY  = OUTCOME_W'(4);
    localparam logic [OUTCOME_W-1:0] OUTCOME_LAST_KNOWN  = OUTCOME_W'(8);

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_COOLDOWN  = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_WINDOW    = 2'd2,
        REG_LOCKOUT   = 2'd3
    } flal_reg_t;

    // configuration as seen by the step logic, durations already in us
    typedef struct packed {
        logic [PROD_W-1:0]   cooldown_us;
        logic [PROD_W-1:0]   window_us;
        logic [PROD_W-1:0]   lockout_us;
        logic [THRESH_W-1:0] threshold;
    } flal_cfg_t;

    // per-word status flags of one result
    typedef struct packed {
        logic match_ran;
        logic lockout_released;
        logic fail_event;
        logic lockout_armed;
        logic match_event;
        logic persist_clear_req;
        logic persist_save_req;
        logic ready_valid;
        logic sensor_ready;
    } flal_flags_t;

endpackage

>>> rtl/core/flal_cfg.sv
// apb configuration registers with durations pre-scaled to microseconds
module flal_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [flal_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [flal_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [flal_pkg::APB_DATA_W-1:0]   prdata,
    output flal_pkg::flal_cfg_t               cfg
);

    logic [flal_pkg::MS_W-1:0]     cooldown_ms_reg;
    logic [flal_pkg::MS_W-1:0]     window_ms_reg;
    logic [flal_pkg::MS_W-1:0]     lockout_ms_reg;
    logic [flal_pkg::THRESH_W-1:0] threshold_reg;
    logic [flal_pkg::PROD_W-1:0]   cooldown_us_reg;
    logic [flal_pkg::PROD_W-1:0]   window_us_reg;
    logic [flal_pkg::PROD_W-1:0]   lockout_us_reg;

    logic                          wr_en;
    flal_pkg::flal_reg_t           reg_sel;
    logic [flal_pkg::PROD_W-1:0]   wdata_us;

    assign wr_en    = psel & penable & pwrite;
    assign reg_sel  = flal_pkg::flal_reg_t'(paddr[3:2]);
    assign wdata_us = flal_pkg::PROD_W'(pwdata[flal_pkg::MS_W-1:0])
                    * flal_pkg::PROD_W'(flal_pkg::US_PER_MS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cooldown_ms_reg <= flal_pkg::COOLDOWN_MS_RST;
            threshold_reg   <= flal_pkg::THRESHOLD_RST;
            window_ms_reg   <= flal_pkg::WINDOW_MS_RST;
            lockout_ms_reg  <= flal_pkg::LOCKOUT_MS_RST;
            cooldown_us_reg <= flal_pkg::PROD_W'(flal_pkg::COOLDOWN_MS_RST)
                             * flal_pkg::PROD_W'(flal_pkg::US_PER_MS);
            window_us_reg   <= flal_pkg::PROD_W'(flal_pkg::WINDOW_MS_RST)
                             * flal_pkg::PROD_W'(flal_pkg::US_PER_MS);
            lockout_us_reg  <= flal_pkg::PROD_W'(flal_pkg::LOCKOUT_MS_RST)
                             * flal_pkg::PROD_W'(flal_pkg::US_PER_MS);
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                flal_pkg::REG_COOLDOWN:
                begin
                    cooldown_ms_reg <= pwdata[flal_pkg::MS_W-1:0];
                    cooldown_us_reg <= wdata_us;
                end
                flal_pkg::REG_THRESHOLD:
                begin
                    threshold_reg <= pwdata[flal_pkg::THRESH_W-1:0];
                end
                flal_pkg::REG_WINDOW:
                begin
                    window_ms_reg <= pwdata[flal_pkg::MS_W-1:0];
                    window_us_reg <= wdata_us;
                end
                flal_pkg::REG_LOCKOUT:
                begin
                    lockout_ms_reg <= pwdata[flal_pkg::MS_W-1:0];
                    lockout_us_reg <= wdata_us;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            flal_pkg::REG_COOLDOWN:  prdata = flal_pkg::APB_DATA_W'(cooldown_ms_reg);
            flal_pkg::REG_THRESHOLD: prdata = flal_pkg::APB_DATA_W'(threshold_reg);
            flal_pkg::REG_WINDOW:    prdata = flal_pkg::APB_DATA_W'(window_ms_reg);
            flal_pkg::REG_LOCKOUT:   prdata = flal_pkg::APB_DATA_W'(lockout_ms_reg);
            default:                 prdata = '0;
        endcase
    end

    assign cfg.cooldown_us = cooldown_us_reg;
    assign cfg.window_us   = window_us_reg;
    assign cfg.lockout_us  = lockout_us_reg;
    assign cfg.threshold   = threshold_reg;

endmodule

>>> rtl/core/flal_step.sv
// single-pass evaluation of one match attempt against the limiter state
module flal_step #(
    parameter int TIME_BITS    = flal_pkg::TIME_BITS_DEF,
    parameter int USER_ID_BITS = flal_pkg::USER_ID_BITS_DEF
) (
    input  flal_pkg::flal_cfg_t                cfg,
    input  logic [TIME_BITS-1:0]               now,
    input  logic                               enrolled,
    input  logic                               busy,
    input  logic [flal_pkg::OUTCOME_W-1:0]     outcome,
    input  logic [USER_ID_BITS-1:0]            user,
    input  logic [flal_pkg::PERM_W-1:0]        perm,
    input  logic [TIME_BITS-1:0]               lockout_until,
    input  logic [flal_pkg::COUNT_W-1:0]       fail_count,
    input  logic [TIME_BITS-1:0]               window_start,
    input  logic [TIME_BITS-1:0]               cooldown_until,
    input  logic                               persist_armed,
    output logic [TIME_BITS-1:0]               lockout_until_next,
    output logic [flal_pkg::COUNT_W-1:0]       fail_count_next,
    output logic [TIME_BITS-1:0]               window_start_next,
    output logic [TIME_BITS-1:0]               cooldown_until_next,
    output logic                               persist_armed_next,
    output flal_pkg::flal_flags_t              flags,
    output logic [flal_pkg::COUNT_W-1:0]       fail_count_res,
    output logic [USER_ID_BITS-1:0]            user_res,
    output logic [flal_pkg::PERM_W-1:0]        perm_res
);

    localparam int SUM_W = ((TIME_BITS > flal_pkg::PROD_W) ? TIME_BITS
                                                            : flal_pkg::PROD_W) + 1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    logic [SUM_W-1:0]             cool_sum;
    logic [SUM_W-1:0]             lock_sum;
    logic [TIME_BITS-1:0]         cool_sat;
    logic [TIME_BITS-1:0]         lock_sat;
    logic                         expire;
    logic                         allowed;
    logic [TIME_BITS-1:0]         ws1;
    logic [flal_pkg::COUNT_W-1:0] fc1;
    logic                         pa1;
    logic [TIME_BITS-1:0]         win_diff;
    logic                         win_expired;
    logic                         win_restart;
    logic [flal_pkg::COUNT_W-1:0] fc_base;
    logic [flal_pkg::COUNT_W-1:0] fc_inc;
    logic                         arm;

    // saturating deadlines, both computed in parallel
    assign cool_sum = SUM_W'(now) + SUM_W'(cfg.cooldown_us);
    assign lock_sum = SUM_W'(now) + SUM_W'(cfg.lockout_us);
    assign cool_sat = (cool_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : cool_sum[TIME_BITS-1:0];
    assign lock_sat = (lock_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : lock_sum[TIME_BITS-1:0];

    assign expire  = (lockout_until != '0) && (now >= lockout_until);
    assign ws1     = expire ? '0 : window_start;
    assign fc1     = expire ? '0 : fail_count;
    assign pa1     = expire ? 1'b0 : persist_armed;
    // a live lockout blocks, an expired or absent one does not
    assign allowed = (now >= cooldown_until) && !busy
                   && ((lockout_until == '0) || (now >= lockout_until));

    // time running backwards keeps the window open
    assign win_diff    = now - ws1;
    assign win_expired = (now >= ws1) && (SUM_W'(win_diff) > SUM_W'(cfg.window_us));
    assign win_restart = (ws1 == '0) || win_expired;
    assign fc_base     = win_restart ? '0 : fc1;
    assign fc_inc      = (fc_base == flal_pkg::COUNT_MAX) ? fc_base
                                                           : fc_base + flal_pkg::COUNT_W'(1);
    assign arm         = (fc_inc >= cfg.threshold);

    always_comb
    begin
        lockout_until_next  = lockout_until;
        fail_count_next     = fail_count;
        window_start_next   = window_start;
        cooldown_until_next = cooldown_until;
        persist_armed_next  = persist_armed;
        flags               = '0;
        fail_count_res      = '0;
        user_res            = '0;
        perm_res            = '0;

        if (enrolled)
        begin
            if (expire)
            begin
                lockout_until_next      = '0;
                flags.lockout_released  = 1'b1;
                flags.persist_clear_req = 1'b1;
            end
            fail_count_next    = fc1;
            window_start_next  = ws1;
            persist_armed_next = pa1;

            if (allowed)
            begin
                flags.match_ran     = 1'b1;
                cooldown_until_next = cool_sat;
                if (outcome <= flal_pkg::OUTCOME_LAST_KNOWN)
                begin
                    flags.ready_valid  = 1'b1;
                    flags.sensor_ready = (outcome <= flal_pkg::OUTCOME_LAST_READY);
                end

                if (outcome == flal_pkg::OUTCOME_NO_MATCH)
                begin
                    flags.fail_event = 1'b1;
                    fail_count_res   = fc_inc;
                    if (arm)
                    begin
                        lockout_until_next     = lock_sat;
                        fail_count_next        = '0;
                        window_start_next      = '0;
                        persist_armed_next     = 1'b1;
                        flags.lockout_armed    = 1'b1;
                        flags.persist_save_req = 1'b1;
                    end
                    else
                    begin
                        fail_count_next   = fc_inc;
                        window_start_next = win_restart ? now : ws1;
                    end
                end
                else if (outcome == flal_pkg::OUTCOME_OK)
                begin
                    fail_count_next    = '0;
                    window_start_next  = '0;
                    persist_armed_next = 1'b0;
                    if (pa1)
                    begin
                        flags.persist_clear_req = 1'b1;
                    end
                    flags.match_event = 1'b1;
                    user_res          = user;
                    perm_res          = perm;
                end
            end
        end
    end

endmodule

>>> rtl/core/failed_attempt_lockout_limiter_unit.sv
// top level of the failed attempt lockout limiter
// Each input word is one biometric match attempt (timestamp in us, enrolment
// and busy flags, sensor outcome, matched user and permission) and yields
// exactly one result word. The block takes a word into an input register,
// evaluates it in one pass of compare and add logic against the lockout,
// failure count, window and cooldown state, and writes state and result
// register at the same edge, so the next word sees the updated state. It
// sustains one word per clock while out_stall is low. A stalled result holds
// the word behind it in the input register, so at most two words are in
// flight and in_stall is raised only while both registers are full and
// out_stall is high. Durations are written in ms over the apb port and are
// scaled to us at the same edge as the write, so words may follow a
// configuration write straight away. All deadlines saturate at the largest
// timestamp; a lockout or window start of zero means none.
module failed_attempt_lockout_limiter_unit #(
    parameter int TIME_BITS    = flal_pkg::TIME_BITS_DEF,
    parameter int USER_ID_BITS = flal_pkg::USER_ID_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // apb configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [flal_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [flal_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [flal_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // attempt words
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [TIME_BITS-1:0]              now_us,
    input  logic                              users_enrolled,
    input  logic                              enroll_busy,
    input  logic [flal_pkg::OUTCOME_W-1:0]    outcome,
    input  logic [USER_ID_BITS-1:0]           user_in,
    input  logic [flal_pkg::PERM_W-1:0]       permission_in,
    // result words
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              match_ran,
    output logic                              lockout_released,
    output logic                              fail_event,
    output logic [flal_pkg::COUNT_W-1:0]      fail_count_out,
    output logic                              lockout_armed,
    output logic                              match_event,
    output logic [USER_ID_BITS-1:0]           user_out,
    output logic [flal_pkg::PERM_W-1:0]       permission_out,
    output logic                              persist_clear_req,
    output logic                              persist_save_req,
    output logic                              ready_valid,
    output logic                              sensor_ready
);

    flal_pkg::flal_cfg_t          cfg;

    // input register
    logic                         in_v_reg;
    logic                         in_v_next;
    logic [TIME_BITS-1:0]         now_reg;
    logic                         enrolled_reg;
    logic                         busy_reg;
    logic [flal_pkg::OUTCOME_W-1:0] outcome_reg;
    logic [USER_ID_BITS-1:0]      user_reg;
    logic [flal_pkg::PERM_W-1:0]  perm_reg;

    // limiter state
    logic [TIME_BITS-1:0]         lockout_until_reg;
    logic [TIME_BITS-1:0]         lockout_until_next;
    logic [flal_pkg::COUNT_W-1:0] fail_count_reg;
    logic [flal_pkg::COUNT_W-1:0] fail_count_next;
    logic [TIME_BITS-1:0]         window_start_reg;
    logic [TIME_BITS-1:0]         window_start_next;
    logic [TIME_BITS-1:0]         cooldown_until_reg;
    logic [TIME_BITS-1:0]         cooldown_until_next;
    logic                         persist_armed_reg;
    logic                         persist_armed_next;

    // result register
    logic                         out_v_reg;
    logic                         out_v_next;
    flal_pkg::flal_flags_t        flags_reg;
    flal_pkg::flal_flags_t        step_flags;
    logic [flal_pkg::COUNT_W-1:0] fail_count_out_reg;
    logic [flal_pkg::COUNT_W-1:0] step_fail_count;
    logic [USER_ID_BITS-1:0]      user_out_reg;
    logic [USER_ID_BITS-1:0]      step_user;
    logic [flal_pkg::PERM_W-1:0]  perm_out_reg;
    logic [flal_pkg::PERM_W-1:0]  step_perm;

    logic                         advance;
    logic                         in_take;

    assign pready = 1'b1;

    flal_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // the word in the input register moves on whenever the result slot is
    // free or being emptied this cycle; state commits at that same edge
    assign advance   = in_v_reg && (!out_v_reg || !out_stall);
    assign in_stall  = in_v_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign in_v_next = in_take ? 1'b1 : (advance ? 1'b0 : in_v_reg);
    assign out_v_next = advance ? 1'b1 : (out_v_reg && out_stall);

    flal_step #(
        .TIME_BITS    (TIME_BITS),
        .USER_ID_BITS (USER_ID_BITS)
    ) u_step (
        .cfg                 (cfg),
        .now                 (now_reg),
        .enrolled            (enrolled_reg),
        .busy                (busy_reg),
        .outcome             (outcome_reg),
        .user                (user_reg),
        .perm                (perm_reg),
        .lockout_until       (lockout_until_reg),
        .fail_count          (fail_count_reg),
        .window_start        (window_start_reg),
        .cooldown_until      (cooldown_until_reg),
        .persist_armed       (persist_armed_reg),
        .lockout_until_next  (lockout_until_next),
        .fail_count_next     (fail_count_next),
        .window_start_next   (window_start_next),
        .cooldown_until_next (cooldown_until_next),
        .persist_armed_next  (persist_armed_next),
        .flags               (step_flags),
        .fail_count_res      (step_fail_count),
        .user_res            (step_user),
        .perm_res            (step_perm)
    );

    // handshake and limiter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg           <= 1'b0;
            out_v_reg          <= 1'b0;
            lockout_until_reg  <= '0;
            fail_count_reg     <= '0;
            window_start_reg   <= '0;
            cooldown_until_reg <= '0;
            persist_armed_reg  <= 1'b0;
        end
        else
        begin
            in_v_reg  <= in_v_next;
            out_v_reg <= out_v_next;
            if (advance)
            begin
                lockout_until_reg  <= lockout_until_next;
                fail_count_reg     <= fail_count_next;
                window_start_reg   <= window_start_next;
                cooldown_until_reg <= cooldown_until_next;
                persist_armed_reg  <= persist_armed_next;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            now_reg      <= now_us;
            enrolled_reg <= users_enrolled;
            busy_reg     <= enroll_busy;
            outcome_reg  <= outcome;
            user_reg     <= user_in;
            perm_reg     <= permission_in;
        end
        if (advance)
        begin
            flags_reg          <= step_flags;
            fail_count_out_reg <= step_fail_count;
            user_out_reg       <= step_user;
            perm_out_reg       <= step_perm;
        end
    end

    assign out_valid         = out_v_reg;
    assign match_ran         = flags_reg.match_ran;
    assign lockout_released  = flags_reg.lockout_released;
    assign fail_event        = flags_reg.fail_event;
    assign fail_count_out    = fail_count_out_reg;
    assign lockout_armed     = flags_reg.lockout_armed;
    assign match_event       = flags_reg.match_event;
    assign user_out          = user_out_reg;
    assign permission_out    = perm_out_reg;
    assign persist_clear_req = flags_reg.persist_clear_req;
    assign persist_save_req  = flags_reg.persist_save_req;
    assign ready_valid       = flags_reg.ready_valid;
    assign sensor_ready      = flags_reg.sensor_ready;

`ifndef SYNTH
    // a held input word keeps its timestamp while it waits
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_v_reg && !advance |=> in_v_reg && $stable(now_reg))
        else $error("input word lost or changed while waiting");

    // arming a lockout leaves an empty count and an armed persist record
    a_arm_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance && step_flags.lockout_armed |=>
            fail_count_reg == '0 && window_start_reg == '0 && persist_armed_reg)
        else $error("lockout armed without clearing the failure count");

    // a run never moves the cooldown deadline behind the attempt time
    a_cooldown: assert property (@(posedge clk) disable iff (!rst_n)
        advance && step_flags.match_ran |=> cooldown_until_reg >= $past(now_reg))
        else $error("cooldown deadline behind attempt time");

    // only a lockout that exists can be cleared
    a_clear_src: assert property (@(posedge clk) disable iff (!rst_n)
        advance && step_flags.lockout_released |-> lockout_until_reg != '0)
        else $error("lockout cleared with none active");
`endif

endmodule

>>> tb/sv/failed_attempt_lockout_limiter_unit_test.sv
// self-checking testbench for the failed attempt lockout limiter
`timescale 1ns / 100ps

module failed_attempt_lockout_limiter_unit_test;

    localparam int TB_TIME_W    = flal_pkg::TIME_BITS_DEF;
    localparam int TB_USER_W    = flal_pkg::USER_ID_BITS_DEF;
    localparam int TB_OUTCOME_W = flal_pkg::OUTCOME_W;
    localparam int TB_PERM_W    = flal_pkg::PERM_W;
    localparam int TB_COUNT_W   = flal_pkg::COUNT_W;
    localparam int TB_MS_W      = flal_pkg::MS_W;
    localparam int TB_THRESH_W  = flal_pkg::THRESH_W;
    localparam logic [TB_TIME_W-1:0] TIME_MAX = {TB_TIME_W{1'b1}};

    // outcome codes the package does not name, apart from 4 and 8, which it names as range limits
    localparam logic [TB_OUTCOME_W-1:0] OUTCOME_FULL           = TB_OUTCOME_W'(2);
    localparam logic [TB_OUTCOME_W-1:0] OUTCOME_USER_TAKEN     = TB_OUTCOME_W'(3);
    localparam logic [TB_OUTCOME_W-1:0] OUTCOME_FINGER_TAKEN   = TB_OUTCOME_W'(4);
    localparam logic [TB_OUTCOME_W-1:0] OUTCOME_TIMEOUT        = TB_OUTCOME_W'(5);
    localparam logic [TB_OUTCOME_W-1:0] OUTCOME_IO_ERROR       = TB_OUTCOME_W'(6);
    localparam logic [TB_OUTCOME_W-1:0] OUTCOME_PROTOCOL_ERROR = TB_OUTCOME_W'(7);
    localparam logic [TB_OUTCOME_W-1:0] OUTCOME_FAILED         = TB_OUTCOME_W'(8);
    localparam logic [TB_OUTCOME_W-1:0] OUTCOME_OTHER          = TB_OUTCOME_W'(9);
    localparam logic [TB_OUTCOME_W-1:0] OUTCOME_TOP_CODE       = TB_OUTCOME_W'(15);

    localparam int IDLE_PCT       = 36;
    // receiver hold-off: starts once this many results have been checked
    localparam int HOLD_AFTER     = 120;
    localparam int HOLD_CYCLES    = 250;
    // longest honest silence is the hold-off plus a configuration pass
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct packed {
        logic [TB_TIME_W-1:0]    now;
        logic                    enrolled;
        logic                    busy;
        logic [TB_OUTCOME_W-1:0] outcome;
        logic [TB_USER_W-1:0]    user;
        logic [TB_PERM_W-1:0]    perm;
    } attempt_t;

    typedef struct packed {
        logic                  match_ran;
        logic                  lockout_released;
        logic                  fail_event;
        logic [TB_COUNT_W-1:0] fail_count_out;
        logic                  lockout_armed;
        logic                  match_event;
        logic [TB_USER_W-1:0]  user_out;
        logic [TB_PERM_W-1:0]  permission_out;
        logic                  persist_clear_req;
        logic                  persist_save_req;
        logic                  ready_valid;
        logic                  sensor_ready;
    } verdict_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // apb side
    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [flal_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [flal_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [flal_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // attempt words in
    logic                    in_valid       = 1'b0;
    logic                    in_stall;
    logic [TB_TIME_W-1:0]    now_us         = '0;
    logic                    users_enrolled = 1'b0;
    logic                    enroll_busy    = 1'b0;
    logic [TB_OUTCOME_W-1:0] outcome        = '0;
    logic [TB_USER_W-1:0]    user_in        = '0;
    logic [TB_PERM_W-1:0]    permission_in  = '0;

    // result words out
    logic                  out_valid;
    logic                  out_stall      = 1'b0;
    logic                  match_ran;
    logic                  lockout_released;
    logic                  fail_event;
    logic [TB_COUNT_W-1:0] fail_count_out;
    logic                  lockout_armed;
    logic                  match_event;
    logic [TB_USER_W-1:0]  user_out;
    logic [TB_PERM_W-1:0]  permission_out;
    logic                  persist_clear_req;
    logic                  persist_save_req;
    logic                  ready_valid;
    logic                  sensor_ready;

    failed_attempt_lockout_limiter_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .now_us            (now_us),
        .users_enrolled    (users_enrolled),
        .enroll_busy       (enroll_busy),
        .outcome           (outcome),
        .user_in           (user_in),
        .permission_in     (permission_in),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .match_ran         (match_ran),
        .lockout_released  (lockout_released),
        .fail_event        (fail_event),
        .fail_count_out    (fail_count_out),
        .lockout_armed     (lockout_armed),
        .match_event       (match_event),
        .user_out          (user_out),
        .permission_out    (permission_out),
        .persist_clear_req (persist_clear_req),
        .persist_save_req  (persist_save_req),
        .ready_valid       (ready_valid),
        .sensor_ready      (sensor_ready)
    );

    always #5 clk = ~clk;

    // attempts waiting to be sent, and verdicts waiting for their result word
    attempt_t attempts[$];
    verdict_t verdicts_due[$];

    // set for a phase in which neither side ever idles
    bit steady = 1'b0;

    int mismatches     = 0;
    int words_sent     = 0;
    int results_seen   = 0;
    int lockouts_seen  = 0;
    int clears_seen    = 0;
    int matches_seen   = 0;

    // shadow of the configuration registers, starts at the reset values
    logic [TB_MS_W-1:0]     cfg_cooldown_ms = flal_pkg::COOLDOWN_MS_RST;
    logic [TB_THRESH_W-1:0] cfg_threshold   = flal_pkg::THRESHOLD_RST;
    logic [TB_MS_W-1:0]     cfg_window_ms   = flal_pkg::WINDOW_MS_RST;
    logic [TB_MS_W-1:0]     cfg_lockout_ms  = flal_pkg::LOCKOUT_MS_RST;

    // shadow of the limiter state
    logic [TB_TIME_W-1:0]  lock_until_q   = '0;
    logic [TB_COUNT_W-1:0] failures_q     = '0;
    logic [TB_TIME_W-1:0]  window_start_q = '0;
    logic [TB_TIME_W-1:0]  cool_until_q   = '0;
    logic                  heal_pending_q = 1'b0;

    // running timestamp used while building stimulus
    logic [TB_TIME_W-1:0] clock_us = '0;

    // t + ms, in us, clamped at the largest timestamp
    function automatic logic [TB_TIME_W-1:0] deadline(input logic [TB_TIME_W-1:0] t,
                                                      input logic [TB_MS_W-1:0] ms);
        logic [63:0] sum;
        sum = 64'(t) + 64'(ms) * 64'(flal_pkg::US_PER_MS);
        return (sum > 64'(TIME_MAX)) ? TIME_MAX : sum[TB_TIME_W-1:0];
    endfunction

    // applies one attempt to the shadow state and returns the result word it causes
    function automatic verdict_t judge_attempt(input attempt_t a);
        verdict_t v;
        logic     expired;
        v = '0;
        if (a.enrolled) begin
            // an expired lockout is cleared before anything else
            if (lock_until_q != '0 && a.now >= lock_until_q) begin
                lock_until_q   = '0;
                failures_q     = '0;
                window_start_q = '0;
                heal_pending_q = 1'b0;
                v.lockout_released  = 1'b1;
                v.persist_clear_req = 1'b1;
            end
            if (a.now >= cool_until_q && !a.busy && a.now >= lock_until_q) begin
                v.match_ran = 1'b1;
                if (a.outcome <= flal_pkg::OUTCOME_LAST_KNOWN) begin
                    v.ready_valid  = 1'b1;
                    v.sensor_ready = (a.outcome <= flal_pkg::OUTCOME_LAST_READY);
                end
                cool_until_q = deadline(a.now, cfg_cooldown_ms);
                if (a.outcome == flal_pkg::OUTCOME_NO_MATCH) begin
                    // time running backwards never counts as an elapsed window
                    expired = (a.now >= window_start_q) &&
                              (64'(a.now - window_start_q) >
                               64'(cfg_window_ms) * 64'(flal_pkg::US_PER_MS));
                    if (window_start_q == '0 || expired) begin
                        window_start_q = a.now;
                        failures_q     = '0;
                    end
                    if (failures_q != flal_pkg::COUNT_MAX)
                        failures_q = failures_q + TB_COUNT_W'(1);
                    v.fail_event     = 1'b1;
                    v.fail_count_out = failures_q;
                    if (failures_q >= cfg_threshold) begin
                        lock_until_q   = deadline(a.now, cfg_lockout_ms);
                        failures_q     = '0;
                        window_start_q = '0;
                        heal_pending_q = 1'b1;
                        v.lockout_armed    = 1'b1;
                        v.persist_save_req = 1'b1;
                    end
                end
                else if (a.outcome == flal_pkg::OUTCOME_OK) begin
                    failures_q     = '0;
                    window_start_q = '0;
                    // a success heals a persisted lockout that was never cleared
                    if (heal_pending_q)
                        v.persist_clear_req = 1'b1;
                    heal_pending_q   = 1'b0;
                    v.match_event    = 1'b1;
                    v.user_out       = a.user;
                    v.permission_out = a.perm;
                end
            end
        end
        return v;
    endfunction

    function automatic void compare_field(input string field, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // driver: presents queued attempts, predicts each one as it is taken
    attempt_t sent_word;
    verdict_t new_verdict;

    always @(posedge clk) begin
        if (in_valid && !in_stall) begin
            new_verdict = judge_attempt(sent_word);
            verdicts_due.push_back(new_verdict);
            words_sent++;
        end
        if (!in_valid || !in_stall) begin
            if (attempts.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                sent_word = attempts.pop_front();
                in_valid       <= 1'b1;
                now_us         <= sent_word.now;
                users_enrolled <= sent_word.enrolled;
                enroll_busy    <= sent_word.busy;
                outcome        <= sent_word.outcome;
                user_in        <= sent_word.user;
                permission_in  <= sent_word.perm;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result word against the oldest verdict, drives out_stall
    verdict_t due;
    int       hold_left = 0;
    bit       hold_done = 1'b0;

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: result word arrived with none expected", $time);
                mismatches++;
            end
            else begin
                due = verdicts_due.pop_front();
                compare_field("match_ran", due.match_ran, match_ran);
                compare_field("lockout_released", due.lockout_released, lockout_released);
                compare_field("fail_event", due.fail_event, fail_event);
                compare_field("fail_count_out", due.fail_count_out, fail_count_out);
                compare_field("lockout_armed", due.lockout_armed, lockout_armed);
                compare_field("match_event", due.match_event, match_event);
                compare_field("user_out", due.user_out, user_out);
                compare_field("permission_out", due.permission_out, permission_out);
                compare_field("persist_clear_req", due.persist_clear_req, persist_clear_req);
                compare_field("persist_save_req", due.persist_save_req, persist_save_req);
                compare_field("ready_valid", due.ready_valid, ready_valid);
                compare_field("sensor_ready", due.sensor_ready, sensor_ready);
                if (due.lockout_armed)
                    lockouts_seen++;
                if (due.lockout_released)
                    clears_seen++;
                if (due.match_event)
                    matches_seen++;
            end
            results_seen++;
        end
        // one long hold-off so the pipeline backs up into in_stall
        if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // watchdog: counts cycles in which neither side moves a word
    int idle_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[failed_attempt_lockout_limiter_unit] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // apb write: setup cycle, then access cycle; pready is always high
    task automatic write_register(input flal_pkg::flal_reg_t idx,
                                  input logic [TB_MS_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            flal_pkg::REG_COOLDOWN:  cfg_cooldown_ms = value;
            flal_pkg::REG_THRESHOLD: cfg_threshold   = value[TB_THRESH_W-1:0];
            flal_pkg::REG_WINDOW:    cfg_window_ms   = value;
            flal_pkg::REG_LOCKOUT:   cfg_lockout_ms  = value;
            default:                 ;
        endcase
    endtask

    task automatic configure(input logic [TB_MS_W-1:0] cool_ms,
                             input logic [TB_THRESH_W-1:0] thr,
                             input logic [TB_MS_W-1:0] win_ms,
                             input logic [TB_MS_W-1:0] lock_ms);
        write_register(flal_pkg::REG_COOLDOWN, cool_ms);
        write_register(flal_pkg::REG_THRESHOLD, TB_MS_W'(thr));
        write_register(flal_pkg::REG_WINDOW, win_ms);
        write_register(flal_pkg::REG_LOCKOUT, lock_ms);
        // a short gap between configuration and the next burst of words
        repeat (2) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic queue_attempt(input logic [TB_TIME_W-1:0] t, input logic enrolled,
                                 input logic busy, input logic [TB_OUTCOME_W-1:0] code,
                                 input logic [TB_USER_W-1:0] user,
                                 input logic [TB_PERM_W-1:0] perm);
        attempt_t a;
        a.now      = t;
        a.enrolled = enrolled;
        a.busy     = busy;
        a.outcome  = code;
        a.user     = user;
        a.perm     = perm;
        attempts.push_back(a);
    endtask

    // mostly enrolled, idle-sensor attempts with random content and a forward clock;
    // some noise: no users, enrolment busy, stray codes and backwards timestamps
    task automatic random_phase(input int count, input int max_step, input int fail_pct);
        int                      pick;
        logic [TB_TIME_W-1:0]    t;
        logic [TB_OUTCOME_W-1:0] code;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 19) == 0)
                clock_us += TB_TIME_W'($urandom_range(0, max_step * 20));
            else
                clock_us += TB_TIME_W'($urandom_range(0, max_step));
            t = clock_us;
            if ($urandom_range(0, 39) == 0 && clock_us > TB_TIME_W'(max_step))
                t = clock_us - TB_TIME_W'($urandom_range(0, max_step));
            pick = $urandom_range(0, 99);
            if (pick < fail_pct)
                code = flal_pkg::OUTCOME_NO_MATCH;
            else if (pick < fail_pct + 25)
                code = flal_pkg::OUTCOME_OK;
            else
                code = TB_OUTCOME_W'($urandom_range(0, 15));
            queue_attempt(t, $urandom_range(0, 15) != 0, $urandom_range(0, 11) == 0, code,
                          TB_USER_W'($urandom()), TB_PERM_W'($urandom()));
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (attempts.size() != 0 || in_valid || verdicts_due.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // stale persisted lockout: a zero-length lockout armed at time zero reads
        // as none, so the following success is allowed and heals it
        configure(32'd0, 8'd1, 32'd10, 32'd0);
        queue_attempt('0, 1'b0, 1'b0, flal_pkg::OUTCOME_NO_MATCH, '0, '0);
        queue_attempt('0, 1'b1, 1'b1, flal_pkg::OUTCOME_NO_MATCH, '0, '0);
        queue_attempt('0, 1'b1, 1'b0, flal_pkg::OUTCOME_NO_MATCH, '0, '0);
        queue_attempt('0, 1'b1, 1'b0, flal_pkg::OUTCOME_OK, '1, '1);
        queue_attempt('0, 1'b1, 1'b0, flal_pkg::OUTCOME_OK, '0, '0);
        wait_drained();

        // cooldown, busy gate, arming, expiry clear, outcome codes 0 to 9 and 15,
        // window expiry and a backwards timestamp
        configure(32'd1, 8'd2, 32'd10, 32'd5);
        queue_attempt(48'd1000, 1'b1, 1'b0, flal_pkg::OUTCOME_NO_MATCH, '0, '0);
        queue_attempt(48'd1500, 1'b1, 1'b0, flal_pkg::OUTCOME_NO_MATCH, '0, '0);
        queue_attempt(48'd2000, 1'b1, 1'b1, flal_pkg::OUTCOME_NO_MATCH, '0, '0);
        queue_attempt(48'd2000, 1'b1, 1'b0, flal_pkg::OUTCOME_NO_MATCH, '0, '0);
        queue_attempt(48'd3000, 1'b1, 1'b0, flal_pkg::OUTCOME_OK, 8'h5a, 8'ha5);
        queue_attempt(48'd7000, 1'b1, 1'b0, OUTCOME_TIMEOUT, '0, '0);
        queue_attempt(48'd8000, 1'b1, 1'b0, OUTCOME_OTHER, '0, '0);
        queue_attempt(48'd9000, 1'b1, 1'b0, OUTCOME_TOP_CODE, '0, '0);
        queue_attempt(48'd10000, 1'b1, 1'b0, OUTCOME_FULL, '0, '0);
        queue_attempt(48'd11000, 1'b1, 1'b0, OUTCOME_USER_TAKEN, '0, '0);
        queue_attempt(48'd12000, 1'b1, 1'b0, OUTCOME_FINGER_TAKEN, '0, '0);
        queue_attempt(48'd13000, 1'b1, 1'b0, OUTCOME_IO_ERROR, '0, '0);
        queue_attempt(48'd14000, 1'b1, 1'b0, OUTCOME_PROTOCOL_ERROR, '0, '0);
        queue_attempt(48'd15000, 1'b1, 1'b0, OUTCOME_FAILED, '0, '0);
        queue_attempt(48'd16000, 1'b1, 1'b0, flal_pkg::OUTCOME_NO_MATCH, '0, '0);
        queue_attempt(48'd27000, 1'b1, 1'b0, flal_pkg::OUTCOME_NO_MATCH, '0, '0);
        queue_attempt(48'd26000, 1'b1, 1'b0, flal_pkg::OUTCOME_NO_MATCH, '0, '0);
        clock_us = 48'd27000;
        wait_drained();

        // short durations so windows, cooldowns and lockouts all turn over
        configure($urandom_range(0, 3), TB_THRESH_W'($urandom_range(1, 4)),
                  $urandom_range(1, 30), $urandom_range(0, 20));
        random_phase(170, 4000, 45);
        wait_drained();

        // same again with both sides running flat out
        configure($urandom_range(0, 3), TB_THRESH_W'($urandom_range(1, 4)),
                  $urandom_range(1, 30), $urandom_range(0, 20));
        steady = 1'b1;
        random_phase(130, 4000, 45);
        wait_drained();
        steady = 1'b0;

        // largest threshold over an endless window: the count climbs to its limit
        configure(32'd0, 8'hff, 32'hffff_ffff, $urandom_range(0, 20));
        random_phase(300, 2000, 100);
        wait_drained();

        // reset values restored, clock advancing in seconds
        configure(flal_pkg::COOLDOWN_MS_RST, flal_pkg::THRESHOLD_RST,
                  flal_pkg::WINDOW_MS_RST, flal_pkg::LOCKOUT_MS_RST);
        random_phase(100, 3000000, 50);
        wait_drained();

        // zero threshold and zero window: every counted failure arms
        configure(32'd0, 8'd0, 32'd0, $urandom_range(0, 10));
        random_phase(60, 3000, 50);
        wait_drained();

        // upper half of the time range, random full-width window
        clock_us = {2'b10, 14'($urandom()), 32'($urandom())};
        configure($urandom_range(0, 7), TB_THRESH_W'($urandom_range(0, 6)), $urandom(),
                  $urandom_range(0, 40));
        random_phase(80, 20000, 45);
        wait_drained();

        // largest durations near the top of the time range: deadlines saturate
        configure(32'hffff_ffff, 8'd0, 32'd0, 32'hffff_ffff);
        queue_attempt(TIME_MAX - 48'd1000, 1'b1, 1'b0, flal_pkg::OUTCOME_NO_MATCH, '0, '0);
        queue_attempt(TIME_MAX - 48'd1, 1'b1, 1'b0, flal_pkg::OUTCOME_OK, '1, '1);
        queue_attempt(TIME_MAX, 1'b1, 1'b0, flal_pkg::OUTCOME_OK, TB_USER_W'($urandom()),
                      TB_PERM_W'($urandom()));
        queue_attempt(TIME_MAX, 1'b1, 1'b0, flal_pkg::OUTCOME_NO_MATCH, '0, '0);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("%0d attempts sent, %0d results checked, %0d mismatches",
                 words_sent, results_seen, mismatches);
        $display("%0d lockouts armed, %0d expiries cleared, %0d matches reported",
                 lockouts_seen, clears_seen, matches_seen);
        if (mismatches == 0)
            $display("[failed_attempt_lockout_limiter_unit] OK");
        else
            $display("[failed_attempt_lockout_limiter_unit] ERROR");
        $finish;
    end

endmodule
